FILE: design/t8cpu_pkg.sv
// ----------------------------------------------------------------------------
// t8cpu_pkg
// Shared types and constants of the tiny 8-bit processor step block.
// ----------------------------------------------------------------------------
package t8cpu_pkg;

    localparam int NUM_REGS = 6;
    localparam logic [2:0] PORT_IDX = 3'd6;

    typedef enum logic [1:0] {
        CLS_IMM    = 2'b00,
        CLS_ALU    = 2'b01,
        CLS_COPY   = 2'b10,
        CLS_BRANCH = 2'b11
    } cls_t;

    typedef enum logic [2:0] {
        OP_OR   = 3'd0,
        OP_NAND = 3'd1,
        OP_NOR  = 3'd2,
        OP_AND  = 3'd3,
        OP_ADD  = 3'd4,
        OP_SUB  = 3'd5
    } alu_op_t;

    typedef enum logic [1:0] {
        COND_NEVER = 2'd0,
        COND_ZERO  = 2'd1,
        COND_NEG   = 2'd2,
        COND_NPOS  = 2'd3
    } cond_t;

    // What the arithmetic unit hands back to the execute stage.
    typedef struct packed {
        logic [7:0] value;
        logic       test;
    } alu_res_t;

endpackage

FILE: design/t8cpu_alu.sv
// ----------------------------------------------------------------------------
// t8cpu_alu
// Compute unit and condition test of the processor step.
// ----------------------------------------------------------------------------
module t8cpu_alu (
    input  logic [7:0]          instr,
    input  logic [7:0]          op_a,
    input  logic [7:0]          op_b,
    input  logic [7:0]          cond_val,
    output t8cpu_pkg::alu_res_t res
);
    import t8cpu_pkg::*;

    logic [7:0] alu_value;
    logic       is_zero;
    logic       is_neg;
    logic       test_raw;

    always_comb
    begin
        case (alu_op_t'(instr[2:0]))
            OP_OR:   alu_value = op_a | op_b;
            OP_NAND: alu_value = ~(op_a & op_b);
            OP_NOR:  alu_value = ~(op_a | op_b);
            OP_AND:  alu_value = op_a & op_b;
            OP_ADD:  alu_value = op_a + op_b;
            OP_SUB:  alu_value = op_a - op_b;
            default: alu_value = 8'd0;
        endcase
    end

    assign is_zero = (cond_val == 8'd0);
    assign is_neg  = cond_val[7];

    always_comb
    begin
        case (cond_t'(instr[1:0]))
            COND_NEVER: test_raw = 1'b0;
            COND_ZERO:  test_raw = is_zero;
            COND_NEG:   test_raw = is_neg;
            default:    test_raw = is_zero | is_neg;
        endcase
    end

    // Bit 2 inverts the chosen test.
    assign res = {alu_value, test_raw ^ instr[2]};

endmodule

FILE: design/t8cpu_exec.sv
// ----------------------------------------------------------------------------
// t8cpu_exec
// Architectural state and execution of one instruction.
// ----------------------------------------------------------------------------
module t8cpu_exec (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] instr,
    input  logic [7:0] port_in,
    output logic [7:0] next_pc,
    output logic [7:0] port_out
);
    import t8cpu_pkg::*;

    logic [7:0] regfile_reg  [NUM_REGS];
    logic [7:0] regfile_next [NUM_REGS];
    logic [7:0] out_port_reg;
    logic [7:0] out_port_next;
    logic [7:0] pc_reg;
    logic [7:0] pc_next;
    logic [7:0] src_val;
    logic [2:0] src_idx;
    logic [2:0] dst_idx;
    logic       taken;
    alu_res_t   alu_res;

    t8cpu_alu u_alu (
        .instr    (instr),
        .op_a     (regfile_reg[1]),
        .op_b     (regfile_reg[2]),
        .cond_val (regfile_reg[3]),
        .res      (alu_res)
    );

    assign src_idx = instr[5:3];
    assign dst_idx = instr[2:0];

    // Index six is the port; index seven reads as zero.
    always_comb
    begin
        if (src_idx < 3'(NUM_REGS))
            src_val = regfile_reg[src_idx];
        else if (src_idx == PORT_IDX)
            src_val = port_in;
        else
            src_val = 8'd0;
    end

    always_comb
    begin
        regfile_next  = regfile_reg;
        out_port_next = out_port_reg;
        taken         = 1'b0;
        unique case (cls_t'(instr[7:6]))
            CLS_IMM:
            begin
                regfile_next[0] = instr;
            end
            CLS_ALU:
            begin
                regfile_next[3] = alu_res.value;
            end
            CLS_COPY:
            begin
                if (dst_idx < 3'(NUM_REGS))
                    regfile_next[dst_idx] = src_val;
                else if (dst_idx == PORT_IDX)
                    out_port_next = src_val;
            end
            default:
            begin
                taken = alu_res.test;
            end
        endcase
        pc_next = taken ? regfile_reg[0] : pc_reg + 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
                regfile_reg[i] <= 8'd0;
            out_port_reg <= 8'd0;
            pc_reg       <= 8'd0;
        end
        else if (en)
        begin
            regfile_reg  <= regfile_next;
            out_port_reg <= out_port_next;
            pc_reg       <= pc_next;
        end
    end

    assign next_pc  = pc_next;
    assign port_out = out_port_next;

endmodule

FILE: design/tiny_8bit_cpu_step_top.sv
// ----------------------------------------------------------------------------
// tiny_8bit_cpu_step_top
// Executes one 8-bit instruction per item and reports the new program
// counter and output port value.
//
//   channel | direction | tdata fields (low bit first)
//   s_axis  | in        | instr[7:0], port_in[15:8]
//   m_axis  | out       | next_pc[7:0], port_out[15:8]
//
// One instruction per clock sustained while the output is not stalled; an
// accepted item passes the input register, then the result register.
// The execute stage holds all state and updates it as each item advances,
// so consecutive instructions see each other's results without waiting.
// Reset clears the register file, output port, program counter and both
// valid flags. A stall on the output holds the result and lets at most one
// further item wait in the input register.
// ----------------------------------------------------------------------------
module tiny_8bit_cpu_step_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // instr[7:0], port_in[15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // next_pc[7:0], port_out[15:8]
);
    import t8cpu_pkg::*;

    logic       in_vld_reg;
    logic [7:0] instr_reg;
    logic [7:0] port_in_reg;
    logic       out_vld_reg;
    logic [7:0] next_pc_reg;
    logic [7:0] port_out_reg;
    logic [7:0] next_pc;
    logic [7:0] port_out;
    logic       advance;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_vld_reg <= s_tvalid;
            if (advance)
                out_vld_reg <= 1'b1;
            else if (m_tready)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            instr_reg   <= s_tdata[7:0];
            port_in_reg <= s_tdata[15:8];
        end
        if (advance)
        begin
            next_pc_reg  <= next_pc;
            port_out_reg <= port_out;
        end
    end

    t8cpu_exec u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .instr    (instr_reg),
        .port_in  (port_in_reg),
        .next_pc  (next_pc),
        .port_out (port_out)
    );

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {port_out_reg, next_pc_reg};

endmodule

FILE: design/t8cpu_chk.sv
// ----------------------------------------------------------------------------
// t8cpu_chk
// Port-level checks of the processor step block, bound to the top level.
// ----------------------------------------------------------------------------
module t8cpu_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // A stalled result stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // With the output draining, the block never holds off the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tready |-> s_tready)
        else $error("input stalled although output is ready");

    // An item accepted while the output keeps draining reaches the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && m_tready) ##1 m_tready |=> m_tvalid)
        else $error("accepted item did not reach the output");

endmodule

bind tiny_8bit_cpu_step_top t8cpu_chk u_t8cpu_chk (.*);
